// ===== src/tbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared sizes, types and helpers for the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int SIZE_BITS = 12;
   localparam int BIM_BITS  = SIZE_BITS - 2;
   localparam int GSH_BITS  = SIZE_BITS - 1;
   localparam int BIM_DEPTH = 1 << BIM_BITS;
   localparam int GSH_DEPTH = 1 << GSH_BITS;
   localparam int COUNT_W   = 32;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MIN         = 2'd0;
   localparam ctr_type CTR_MAX         = 2'd3;
   localparam ctr_type CTR_WEAK_TAKEN  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   // bimodal and chooser counters share an index and live in one word
   typedef struct packed {
      ctr_type chooser;
      ctr_type bimodal;
   } bim_word_type;

   function automatic ctr_type sat_toward(ctr_type c, logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + ctr_type'(1);
      end else begin
         if (c != CTR_MIN) r = c - ctr_type'(1);
      end
      return r;
   endfunction

   function automatic logic ctr_says_taken(ctr_type c);
      return (c >= CTR_WEAK_TAKEN);
   endfunction

endpackage

// ===== src/tournament_branch_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Bimodal plus gshare predictor with a per-address chooser, trained by
// resolved conditional branches.
// ----------------------------------------------------------------------------
// Each accepted item (a resolved branch) goes through two steps: the
// synchronous table read, then an update of the counters, their write-back
// and the load of the result register. A new item is accepted only in the
// idle state, not while the previous one is being updated, and only when the
// output register is empty or hands its result over at the same edge. After
// reset a clearing pass covers all 2048 gshare entries (one gshare entry, and
// the matching bimodal/chooser entry, per cycle); req_stall stays high until done.
module tournament_branch_predictor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_branch_address,
   input  logic        req_taken,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_predicted_taken,
   output logic        rsp_mispredicted,
   output logic        rsp_used_gshare,
   output logic [31:0] rsp_mispredict_count
);

   tbp_pkg::state_type state_ff, state_in;

   logic [tbp_pkg::GSH_BITS-1:0] clr_ff, clr_in;
   logic [tbp_pkg::GSH_BITS-1:0] hist_ff, hist_in;
   logic [tbp_pkg::BIM_BITS-1:0] bidx_ff, bidx_in;
   logic [tbp_pkg::GSH_BITS-1:0] gidx_ff, gidx_in;
   logic                         taken_ff, taken_in;
   logic [tbp_pkg::COUNT_W-1:0]  miss_ff, miss_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         pred_ff, pred_in;
   logic                         mis_ff, mis_in;
   logic                         useg_ff, useg_in;

   logic accept;
   logic clearing;
   logic looking;
   logic idle;

   tbp_pkg::bim_word_type        bim_rd, bim_wr;
   tbp_pkg::ctr_type             gsh_rd, gsh_wr;
   logic [tbp_pkg::BIM_BITS-1:0] bim_wr_addr;
   logic [tbp_pkg::GSH_BITS-1:0] gsh_wr_addr;
   logic                         mem_wr_en;

   logic           bpred, gpred, use_g, pred, miss;
   tbp_pkg::ctr_type ch_new;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            if (clr_ff == {tbp_pkg::GSH_BITS{1'b1}}) state_in = tbp_pkg::ST_IDLE;
         end
         tbp_pkg::ST_IDLE: begin
            if (accept) state_in = tbp_pkg::ST_LOOK;
         end
         tbp_pkg::ST_LOOK: begin
            state_in = tbp_pkg::ST_IDLE;
         end
         default: state_in = tbp_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      looking  = 1'b0;
      idle     = 1'b0;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: clearing = 1'b1;
         tbp_pkg::ST_IDLE:  idle     = 1'b1;
         tbp_pkg::ST_LOOK:  looking  = 1'b1;
         default: ;
      endcase
   end

   // slot is free or drains at this edge
   assign req_stall = !idle || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // ---------------- prediction and update ----------------
   always_comb begin
      bpred = tbp_pkg::ctr_says_taken(bim_rd.bimodal);
      gpred = tbp_pkg::ctr_says_taken(gsh_rd);
      use_g = tbp_pkg::ctr_says_taken(bim_rd.chooser);
      pred  = use_g ? gpred : bpred;
      miss  = (pred != taken_ff);

      ch_new = bim_rd.chooser;
      if (bpred == taken_ff && gpred != taken_ff) begin
         ch_new = tbp_pkg::sat_toward(bim_rd.chooser, 1'b0);
      end else if (gpred == taken_ff && bpred != taken_ff) begin
         ch_new = tbp_pkg::sat_toward(bim_rd.chooser, 1'b1);
      end
   end

   always_comb begin
      mem_wr_en = clearing || looking;
      if (clearing) begin
         bim_wr_addr = clr_ff[tbp_pkg::BIM_BITS-1:0];
         gsh_wr_addr = clr_ff;
         bim_wr      = '0;
         gsh_wr      = tbp_pkg::CTR_MIN;
      end else begin
         bim_wr_addr    = bidx_ff;
         gsh_wr_addr    = gidx_ff;
         bim_wr.chooser = ch_new;
         bim_wr.bimodal = tbp_pkg::sat_toward(bim_rd.bimodal, taken_ff);
         gsh_wr         = tbp_pkg::sat_toward(gsh_rd, taken_ff);
      end
   end

   tbp_ram #(
      .WIDTH     ($bits(tbp_pkg::bim_word_type)),
      .ADDR_BITS (tbp_pkg::BIM_BITS)
   ) u_bim_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (bim_wr_addr),
      .wr_data (bim_wr),
      .rd_en   (accept),
      .rd_addr (req_branch_address[tbp_pkg::BIM_BITS-1:0]),
      .rd_data (bim_rd)
   );

   tbp_ram #(
      .WIDTH     ($bits(tbp_pkg::ctr_type)),
      .ADDR_BITS (tbp_pkg::GSH_BITS)
   ) u_gsh_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (gsh_wr_addr),
      .wr_data (gsh_wr),
      .rd_en   (accept),
      .rd_addr (gidx_in),
      .rd_data (gsh_rd)
   );

   // ---------------- next values ----------------
   always_comb begin
      clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;
      hist_in  = hist_ff;
      bidx_in  = bidx_ff;
      taken_in = taken_ff;
      gidx_in  = req_branch_address[tbp_pkg::GSH_BITS-1:0] ^ hist_ff;
      if (accept) begin
         hist_in  = {hist_ff[tbp_pkg::GSH_BITS-2:0], req_taken};
         bidx_in  = req_branch_address[tbp_pkg::BIM_BITS-1:0];
         taken_in = req_taken;
      end

      miss_in = miss_ff;
      if (looking && miss && miss_ff != {tbp_pkg::COUNT_W{1'b1}}) begin
         miss_in = miss_ff + 1'b1;
      end

      pred_in = pred_ff;
      mis_in  = mis_ff;
      useg_in = useg_ff;
      if (looking) begin
         pred_in = pred;
         mis_in  = miss;
         useg_in = use_g;
      end

      rsp_valid_in = rsp_valid_ff;
      if (looking) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         hist_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hist_ff      <= hist_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bidx_ff  <= bidx_in;
      gidx_ff  <= accept ? gidx_in : gidx_ff;
      taken_ff <= taken_in;
      pred_ff  <= pred_in;
      mis_ff   <= mis_in;
      useg_ff  <= useg_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_taken  = pred_ff;
   assign rsp_mispredicted     = mis_ff;
   assign rsp_used_gshare      = useg_ff;
   assign rsp_mispredict_count = miss_ff;

endmodule

// ===== src/tbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tbp_ram #(
   parameter int WIDTH     = 2,
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks for the tournament branch predictor.
// ----------------------------------------------------------------------------
module tbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_branch_address,
   input logic        req_taken,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_predicted_taken,
   input logic        rsp_mispredicted,
   input logic        rsp_used_gshare,
   input logic [31:0] rsp_mispredict_count
);

   logic        seen_ff;
   logic [31:0] last_ff;
   logic [31:0] base;
   logic [32:0] expect_sum;
   logic        rsp_take;
   logic        req_take;

   assign rsp_take   = rsp_valid && !rsp_stall;
   assign req_take   = req_valid && !req_stall;
   assign base       = seen_ff ? last_ff : 32'd0;
   assign expect_sum = {1'b0, base} + {32'd0, rsp_mispredicted};

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         last_ff <= '0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
         last_ff <= rsp_mispredict_count;
      end
   end

   // running count moves by exactly this item's miss, or sits at its ceiling
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_mispredict_count == expect_sum[31:0] && !expect_sum[32]) ||
                   (base == 32'hFFFF_FFFF && rsp_mispredict_count == base))
      else $error("mispredict count step wrong");

   // every accepted item yields a result once its table read and update are done
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##2 rsp_valid)
      else $error("no result for accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_predicted_taken) &&
         $stable(rsp_mispredicted) && $stable(rsp_used_gshare) &&
         $stable(rsp_mispredict_count))
      else $error("stalled result changed");

   // a stalled branch item stays put until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_branch_address) &&
         $stable(req_taken))
      else $error("stalled branch item changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tournament branch predictor. A short table of
// resolved branches covers address extremes and counter saturation, then
// loop, alternating, correlated, biased and random branch streams are sent with
// random address bits and random idle and stall bursts. Every result is
// checked against a cycle-free model of the three counter tables.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ITEMS     = 1850;
   localparam int TAIL_FROM = 1600;
   localparam int LIMIT     = 400000;
   localparam int DIR_N     = 22;
   localparam logic [63:0] UPPER_BITS = ~((64'd1 << tbp_pkg::GSH_BITS) - 64'd1);

   typedef struct packed {
      logic        predicted;
      logic        missed;
      logic        chose_gshare;
      logic [31:0] miss_total;
   } branch_result_type;

   typedef struct packed {
      logic [63:0]       addr;
      logic              tk;
      bit                typed;
      branch_result_type want;
   } branch_row_type;

   typedef enum int {
      PAT_LOOP,
      PAT_ALTERNATE,
      PAT_CORRELATED,
      PAT_BIASED,
      PAT_NOISE
   } pattern_kind_type;

   // fixed expectations only where they follow directly from the cleared tables
   localparam branch_row_type DIR_ROWS [DIR_N] = '{
      '{64'h0000_0000_0000_0000, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 32'd1}},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 32'd2}},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 32'd3}},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_07FF, 1'b1, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_F800, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0400, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0400, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0000_0400, 1'b1, 1'b0, '0},
      '{64'h0000_0000_0000_0400, 1'b0, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_branch_address = '0;
   logic        req_taken = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_predicted_taken;
   logic        rsp_mispredicted;
   logic        rsp_used_gshare;
   logic [31:0] rsp_mispredict_count;

   // model state
   tbp_pkg::ctr_type             bim_ctr [tbp_pkg::BIM_DEPTH];
   tbp_pkg::ctr_type             gsh_ctr [tbp_pkg::GSH_DEPTH];
   tbp_pkg::ctr_type             sel_ctr [tbp_pkg::BIM_DEPTH];
   logic [tbp_pkg::GSH_BITS-1:0] ghist;
   logic [31:0]                  miss_seen;

   branch_result_type expected_outcomes [$];
   int                accepted = 0;
   int                checked = 0;
   int                fail_count = 0;
   int                sent = 0;
   int                cycle_count = 0;
   int                hold_left = 0;
   bit                steady_tail = 1'b0;
   logic [63:0]       hot_addr [16];

   tournament_branch_predictor DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_branch_address   (req_branch_address),
      .req_taken            (req_taken),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_predicted_taken  (rsp_predicted_taken),
      .rsp_mispredicted     (rsp_mispredicted),
      .rsp_used_gshare      (rsp_used_gshare),
      .rsp_mispredict_count (rsp_mispredict_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic tbp_pkg::ctr_type step_counter(tbp_pkg::ctr_type c, logic up);
      if (up) begin
         return (c == tbp_pkg::CTR_MAX) ? c : tbp_pkg::ctr_type'(c + 2'd1);
      end
      return (c == tbp_pkg::CTR_MIN) ? c : tbp_pkg::ctr_type'(c - 2'd1);
   endfunction

   // one resolved branch: prediction from the current tables, then training
   function automatic branch_result_type predict_branch(logic [63:0] addr, logic tk);
      logic [tbp_pkg::BIM_BITS-1:0] bi;
      logic [tbp_pkg::GSH_BITS-1:0] gi;
      tbp_pkg::ctr_type             bc;
      tbp_pkg::ctr_type             gc;
      tbp_pkg::ctr_type             sc;
      logic                         bp;
      logic                         gp;
      branch_result_type            r;
      bi = addr[tbp_pkg::BIM_BITS-1:0];
      gi = addr[tbp_pkg::GSH_BITS-1:0] ^ ghist;
      bc = bim_ctr[bi];
      gc = gsh_ctr[gi];
      sc = sel_ctr[bi];
      bp = (bc >= tbp_pkg::CTR_WEAK_TAKEN);
      gp = (gc >= tbp_pkg::CTR_WEAK_TAKEN);
      r.chose_gshare = (sc >= tbp_pkg::CTR_WEAK_TAKEN);
      r.predicted = r.chose_gshare ? gp : bp;
      r.missed = (r.predicted != tk);
      if (r.missed && miss_seen != 32'hFFFF_FFFF) miss_seen = miss_seen + 32'd1;
      r.miss_total = miss_seen;
      // chooser only moves when exactly one side was right
      if (bp == tk && gp != tk) sel_ctr[bi] = step_counter(sc, 1'b0);
      else if (gp == tk && bp != tk) sel_ctr[bi] = step_counter(sc, 1'b1);
      bim_ctr[bi] = step_counter(bc, tk);
      gsh_ctr[gi] = step_counter(gc, tk);
      ghist = {ghist[tbp_pkg::GSH_BITS-2:0], tk};
      return r;
   endfunction

   task automatic drive_branch(input logic [63:0] addr, input logic tk);
      if (!steady_tail && !cycle_count[10] && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_branch_address <= addr;
      req_taken <= tk;
      do @(posedge clock); while (req_stall);
      sent++;
      if (sent >= TAIL_FROM) steady_tail = 1'b1;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("tournament_branch_predictor regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!steady_tail && !cycle_count[9] && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : scoreboard
      branch_result_type want;
      branch_result_type got;
      if (reset) begin
         for (int i = 0; i < tbp_pkg::BIM_DEPTH; i++) begin
            bim_ctr[i] = tbp_pkg::CTR_MIN;
            sel_ctr[i] = tbp_pkg::CTR_MIN;
         end
         for (int i = 0; i < tbp_pkg::GSH_DEPTH; i++) gsh_ctr[i] = tbp_pkg::CTR_MIN;
         ghist = '0;
         miss_seen = '0;
      end else begin
         if (req_valid && !req_stall) begin
            want = predict_branch(req_branch_address, req_taken);
            if (accepted < DIR_N && DIR_ROWS[accepted].typed) want = DIR_ROWS[accepted].want;
            expected_outcomes.push_back(want);
            accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_predicted_taken, rsp_mispredicted, rsp_used_gshare,
                    rsp_mispredict_count};
            if (expected_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("item with no branch outstanding: %s%0d %0d %0d %0d",
                           "pred/miss/gshare/count=", got.predicted, got.missed,
                           got.chose_gshare, got.miss_total);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.predicted !== want.predicted || got.missed !== want.missed ||
                   got.chose_gshare !== want.chose_gshare ||
                   got.miss_total !== want.miss_total) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("item %0d: expected pred=%0d miss=%0d gshare=%0d count=%0d",
                              checked, want.predicted, want.missed, want.chose_gshare,
                              want.miss_total);
                     $display("item %0d: got      pred=%0d miss=%0d gshare=%0d count=%0d",
                              checked, got.predicted, got.missed, got.chose_gshare,
                              got.miss_total);
                  end
               end
            end
            checked++;
         end
      end
   end

   initial begin : stimulus
      pattern_kind_type kind;
      int               pick;
      int               reps;
      int               trip;
      logic [63:0]      a;
      logic [63:0]      b;
      logic             t;
      for (int i = 0; i < 16; i++) begin
         hot_addr[i] = {$urandom, $urandom};
         // odd entries alias the even one in the bimodal and chooser tables
         if (i % 2 == 1) hot_addr[i] = hot_addr[i-1] ^ (64'd1 << tbp_pkg::BIM_BITS);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) drive_branch(DIR_ROWS[i].addr, DIR_ROWS[i].tk);

      while (sent < ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) kind = PAT_LOOP;
         else if (pick < 5) kind = PAT_ALTERNATE;
         else if (pick < 7) kind = PAT_CORRELATED;
         else if (pick < 9) kind = PAT_BIASED;
         else kind = PAT_NOISE;
         a = hot_addr[$urandom_range(0, 15)] ^ ({$urandom, $urandom} & UPPER_BITS);
         b = hot_addr[$urandom_range(0, 15)] ^ ({$urandom, $urandom} & UPPER_BITS);
         case (kind)
            PAT_LOOP: begin
               trip = $urandom_range(2, 12);
               reps = $urandom_range(2, 5);
               repeat (reps) begin
                  for (int k = 1; k < trip; k++) drive_branch(a, 1'b1);
                  drive_branch(a, 1'b0);
               end
            end
            PAT_ALTERNATE: begin
               t = 1'($urandom_range(0, 1));
               repeat ($urandom_range(6, 16)) begin
                  drive_branch(a, t);
                  t = ~t;
               end
            end
            PAT_CORRELATED: begin
               // second branch repeats the outcome of the first
               repeat ($urandom_range(4, 10)) begin
                  t = 1'($urandom_range(0, 1));
                  drive_branch(a, t);
                  drive_branch(b, t);
               end
            end
            PAT_BIASED: begin
               t = 1'($urandom_range(0, 1));
               repeat ($urandom_range(8, 20))
                  drive_branch(a, ($urandom_range(0, 9) == 0) ? ~t : t);
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  drive_branch({$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end
         endcase
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("tournament_branch_predictor regression: pass");
      end else begin
         $display("tournament_branch_predictor regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tbp_pkg.sv
src/tbp_ram.sv
src/tournament_branch_predictor.sv
src/tbp_checker.sv
dv/testbench.sv
